FILE: hdl/lpf_pkg.sv
// Shared widths and types for the largest prime factor block.
package lpf_pkg;

   localparam int VALUE_WIDTH       = 32;
   localparam int RESULT_WIDTH      = 31;
   localparam int MIN_OPERAND_WIDTH = 8;
   localparam int MAX_OPERAND_WIDTH = 32;

   // Handshake between the sequencer and the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } lpf_div_stat_type;

endpackage

FILE: hdl/lpf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module lpf_div #(
   parameter int WIDTH = 31
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [WIDTH-1:0]          dividend,
   input  logic [WIDTH-1:0]          divisor,
   output lpf_pkg::lpf_div_stat_type stat,
   output logic [WIDTH-1:0]          quotient,
   output logic [WIDTH-1:0]          remainder
);
   import lpf_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the shifted remainder when the subtract borrows
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/largest_prime_factor.sv
// Largest prime factor of a signed integer by trial division.
//
// Input channel req_: one word carries req_value. It is taken when req_valid
// is high and req_stall is low. req_stall stays high from the accepting edge
// until the result has been moved into the output register.
// Result channel rsp_: rsp_largest_prime, held with rsp_valid until taken
// (rsp_valid high, rsp_stall low). A stalled result holds; the next word
// may be accepted while it waits, and that word's result waits in turn.
// Values of one or less, negatives included, give one without entering
// the divisor loop. Otherwise each trial divisor costs one square test and
// one pass through the shared bit-serial divider, sequenced by the test,
// start and wait states, and each factor found costs one more such pass.
// The divisor loop up to the square root of the value sets the worst case:
// about 46341 divisors for a large prime at the default width.
// Reset is synchronous and active high; it returns the sequencer to idle
// and drops any pending result. No state is kept between words.
module largest_prime_factor #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lpf_pkg::VALUE_WIDTH-1:0]   req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lpf_pkg::RESULT_WIDTH-1:0]  rsp_largest_prime
);
   import lpf_pkg::*;

   localparam int OPW = (DATA_WIDTH < MIN_OPERAND_WIDTH) ? MIN_OPERAND_WIDTH :
                        (DATA_WIDTH > MAX_OPERAND_WIDTH) ? MAX_OPERAND_WIDTH :
                        DATA_WIDTH;
   localparam int DW  = OPW - 1;
   localparam int SW  = DW + 2;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TEST = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [DW-1:0]           n_ff, n_in;
   logic [DW-1:0]           d_ff, d_in;
   logic [SW-1:0]           sq_ff, sq_in;
   logic [DW-1:0]           best_ff, best_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic [OPW-1:0]   raw;
   logic [DW-1:0]    raw_mag;
   logic             div_start;
   lpf_div_stat_type div_stat;
   logic [DW-1:0]    div_quo;
   logic [DW-1:0]    div_rem;
   logic             out_free;
   logic [DW-1:0]    answer;

   assign raw       = req_value[OPW-1:0];
   assign raw_mag   = raw[DW-1:0];
   assign div_start = (state_ff == S_DIV);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign answer    = (n_ff > DW'(1)) ? n_ff : best_ff;

   lpf_div #(
      .WIDTH (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      best_in      = best_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               d_in    = DW'(2);
               sq_in   = SW'(4);
               best_in = DW'(1);
               if (raw[OPW-1] || raw_mag <= DW'(1)) begin
                  n_in     = DW'(1);
                  state_in = S_DONE;
               end else begin
                  n_in     = raw_mag;
                  state_in = S_TEST;
               end
            end
         end
         S_TEST: begin
            if (sq_ff <= SW'(n_ff)) state_in = S_DIV;
            else                    state_in = S_DONE;
         end
         S_DIV: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_stat.done) begin
               if (div_rem == '0) begin
                  // divide the factor out again with the same divisor
                  best_in  = d_ff;
                  n_in     = div_quo;
                  state_in = S_DIV;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  sq_in    = sq_ff + SW'({d_ff, 1'b1});
                  d_in     = d_ff + DW'(1);
                  state_in = S_TEST;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RESULT_WIDTH'(answer);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_largest_prime = rsp_data_ff;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the largest prime factor block: directed table then random words.
`timescale 1ns / 1ps

module tb_top;
   import lpf_pkg::*;

   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_WORDS  = 80;
   localparam int CALM_FIRST    = 30;
   localparam int CALM_LAST     = 49;
   localparam int DRAIN_AT      = 60;
   localparam int TAIL_CYCLES   = 50;
   // A large prime runs the whole divisor loop with no handshake in between.
   localparam int STUCK_LIMIT   = 8000000;
   localparam int DIRECTED_ROWS = 21;

   typedef logic [VALUE_WIDTH-1:0]  value_type;
   typedef logic [RESULT_WIDTH-1:0] prime_type;

   typedef struct packed {
      value_type value;
      logic      known;
      prime_type want;
   } factor_row_type;

   localparam factor_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{32'd0,          1'b1, 31'd1},
      '{32'd1,          1'b1, 31'd1},
      '{32'hFFFF_FFFF,  1'b1, 31'd1},
      '{32'h8000_0000,  1'b1, 31'd1},
      '{32'hFFFF_CFC7,  1'b1, 31'd1},
      '{32'hAAAA_AAAA,  1'b1, 31'd1},
      '{32'd2,          1'b1, 31'd2},
      '{32'd3,          1'b1, 31'd3},
      '{32'd4,          1'b1, 31'd2},
      '{32'd12,         1'b1, 31'd3},
      '{32'd1000,       1'b1, 31'd5},
      '{32'd8191,       1'b1, 31'd8191},
      '{32'h0001_0000,  1'b1, 31'd2},
      '{32'h4000_0000,  1'b1, 31'd2},
      '{32'h7FFF_FFFF,  1'b1, 31'h7FFF_FFFF},
      '{32'h7FFF_FFFE,  1'b0, 31'd0},
      '{32'd9409,       1'b0, 31'd0},
      '{32'd65535,      1'b0, 31'd0},
      '{32'd65521,      1'b0, 31'd0},
      '{32'd510510,     1'b0, 31'd0},
      '{32'h5555_5555,  1'b0, 31'd0}
   };

   logic      clock      = 1'b0;
   logic      reset      = 1'b1;
   logic      req_valid  = 1'b0;
   value_type req_value  = '0;
   logic      rsp_stall  = 1'b0;
   logic      req_stall;
   logic      rsp_valid;
   prime_type rsp_largest_prime;

   prime_type pending_primes [$];
   int        error_count = 0;
   int        stuck_cycles = 0;
   bit        calm = 1'b0;

   largest_prime_factor #(
      .DATA_WIDTH(32)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_largest_prime(rsp_largest_prime)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic prime_type largest_factor(input value_type value);
      longint unsigned rest;
      longint unsigned cand;
      longint unsigned best;
      if (value[VALUE_WIDTH-1] || value < 2) return prime_type'(1);
      rest = 64'(value);
      cand = 64'd2;
      best = 64'd1;
      while (cand * cand <= rest) begin
         while (rest % cand == 64'd0) begin
            best = cand;
            rest = rest / cand;
         end
         cand++;
      end
      if (rest > 64'd1) best = rest;
      return best[RESULT_WIDTH-1:0];
   endfunction

   // Keep most operands small so trial division stays short.
   function automatic value_type random_operand();
      int unsigned pick;
      value_type v;
      pick = $urandom_range(99);
      if (pick < 55) begin
         v = $urandom_range(4095, 0);
      end else if (pick < 70) begin
         v = {1'b1, 31'($urandom)};
      end else if (pick < 85) begin
         v = value_type'($urandom_range(255, 1)) << $urandom_range(23, 0);
      end else begin
         v = $urandom_range(1 << 20, 4096);
      end
      return v;
   endfunction

   task automatic send_word(input value_type value, input prime_type want);
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_primes.push_back(want);
      // Idle the sender now and then, outside the calm stretch.
      if (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         req_value <= $urandom;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // Result side: check each taken word, then pick the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_primes.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d",
                        $time, rsp_largest_prime);
               error_count++;
            end else begin
               if (rsp_largest_prime !== pending_primes[0]) begin
                  $display("%0t: largest_prime mismatch, expected %0d, actual %0d",
                           $time, pending_primes[0], rsp_largest_prime);
                  error_count++;
               end
               void'(pending_primes.pop_front());
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 36);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (!reset) begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      value_type v;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         send_word(DIRECTED[i].value,
                   DIRECTED[i].known ? DIRECTED[i].want : largest_factor(DIRECTED[i].value));
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm = (n >= CALM_FIRST && n <= CALM_LAST);
         if (n == DRAIN_AT) begin
            // Hold the sender until every pending result is out.
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_primes.size() != 0) @(posedge clock);
         end
         v = random_operand();
         send_word(v, largest_factor(v));
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_primes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
